// ===== hdl/csl_pkg.sv =====
// Shared types, constants and lookup tables for the C subset lexer.
// No dependencies; the front, queue, back, top level and checker refer to this package.
`default_nettype none

package csl_pkg;

    // Token kind codes
    typedef logic [5:0] t_kind;

    localparam t_kind KIND_IDENT   = 6'd19;
    localparam t_kind KIND_INT     = 6'd20;
    localparam t_kind KIND_NOT     = 6'd21;
    localparam t_kind KIND_NE      = 6'd22;
    localparam t_kind KIND_ADD     = 6'd23;
    localparam t_kind KIND_ADD_EQ  = 6'd24;
    localparam t_kind KIND_INC     = 6'd25;
    localparam t_kind KIND_ASSIGN  = 6'd26;
    localparam t_kind KIND_EQ      = 6'd27;
    localparam t_kind KIND_SUB     = 6'd28;
    localparam t_kind KIND_SUB_EQ  = 6'd29;
    localparam t_kind KIND_DEC     = 6'd30;
    localparam t_kind KIND_MUL     = 6'd31;
    localparam t_kind KIND_MUL_EQ  = 6'd32;
    localparam t_kind KIND_LT      = 6'd33;
    localparam t_kind KIND_LE      = 6'd34;
    localparam t_kind KIND_GT      = 6'd35;
    localparam t_kind KIND_GE      = 6'd36;
    localparam t_kind KIND_BAND    = 6'd37;
    localparam t_kind KIND_LAND    = 6'd38;
    localparam t_kind KIND_BOR     = 6'd39;
    localparam t_kind KIND_LOR     = 6'd40;
    localparam t_kind KIND_MOD     = 6'd41;
    localparam t_kind KIND_TILDE   = 6'd42;
    localparam t_kind KIND_XOR     = 6'd43;
    localparam t_kind KIND_LPAREN  = 6'd44;
    localparam t_kind KIND_RPAREN  = 6'd45;
    localparam t_kind KIND_LBRACK  = 6'd46;
    localparam t_kind KIND_RBRACK  = 6'd47;
    localparam t_kind KIND_LBRACE  = 6'd48;
    localparam t_kind KIND_RBRACE  = 6'd49;
    localparam t_kind KIND_COMMA   = 6'd50;
    localparam t_kind KIND_SEMI    = 6'd51;
    localparam t_kind KIND_DOT     = 6'd52;
    localparam t_kind KIND_QUOTE   = 6'd53;
    localparam t_kind KIND_HASH    = 6'd54;
    localparam t_kind KIND_DIV     = 6'd55;
    localparam t_kind KIND_ERROR   = 6'd56;
    localparam t_kind KIND_NONE    = 6'd0;

    // Keyword table: text left-justified, padded with spaces
    localparam int KW_COUNT   = 19;
    localparam int KW_MAX_LEN = 8;
    localparam int KW_IDX_W   = $clog2(KW_MAX_LEN);

    localparam logic [KW_MAX_LEN*8-1:0] KW_TEXT [KW_COUNT] = '{
        "main    ", "const   ", "break   ", "continue", "return  ",
        "if      ", "else    ", "while   ", "do      ", "for     ",
        "int     ", "float   ", "double  ", "char    ", "void    ",
        "long    ", "short   ", "switch  ", "then    "
    };
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd4, 4'd5, 4'd5, 4'd8, 4'd6, 4'd2, 4'd4, 4'd5, 4'd2, 4'd3,
        4'd3, 4'd5, 4'd6, 4'd4, 4'd4, 4'd4, 4'd5, 4'd6, 4'd4
    };
    localparam logic [KW_COUNT-1:0] KW_ALL = '1;

    // Operators that may take a second character
    typedef struct packed {
        logic [7:0] first;
        t_kind      alone;
        logic [7:0] sec_a;
        t_kind      kind_a;
        logic [7:0] sec_b;
        t_kind      kind_b;
    } t_op_row;

    localparam int OP_COUNT = 9;
    localparam int OP_W     = $clog2(OP_COUNT);
    localparam logic [7:0] CH_NONE = 8'h00;

    localparam t_op_row OP_TAB [OP_COUNT] = '{
        '{"!", KIND_NOT,    "=", KIND_NE,     CH_NONE, KIND_NONE},
        '{"+", KIND_ADD,    "=", KIND_ADD_EQ, "+",     KIND_INC},
        '{"=", KIND_ASSIGN, "=", KIND_EQ,     CH_NONE, KIND_NONE},
        '{"-", KIND_SUB,    "=", KIND_SUB_EQ, "-",     KIND_DEC},
        '{"*", KIND_MUL,    "=", KIND_MUL_EQ, CH_NONE, KIND_NONE},
        '{"<", KIND_LT,     "=", KIND_LE,     CH_NONE, KIND_NONE},
        '{">", KIND_GT,     "=", KIND_GE,     CH_NONE, KIND_NONE},
        '{"&", KIND_BAND,   "&", KIND_LAND,   CH_NONE, KIND_NONE},
        '{"|", KIND_BOR,    "|", KIND_LOR,    CH_NONE, KIND_NONE}
    };

    typedef struct packed {
        logic            hit;
        logic [OP_W-1:0] idx;
    } t_op_hit;

    typedef struct packed {
        logic  hit;
        t_kind kind;
    } t_single;

    // One emitted token and the pair of tokens one byte can cause
    localparam int TOK_START_W = 32;
    localparam int TOK_LEN_W   = 8;

    typedef struct packed {
        t_kind                  kind;
        logic [TOK_START_W-1:0] start;
        logic [TOK_LEN_W-1:0]   length;
        logic                   too_long;
    } t_token;

    typedef struct packed {
        logic   two;
        t_token tok0;
        t_token tok1;
    } t_tok_pair;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Character idx of keyword k (only meaningful below its length)
    function automatic logic [7:0] kw_char(input int k, input logic [KW_IDX_W-1:0] idx);
        return KW_TEXT[k][(KW_MAX_LEN*8-1) - 8*idx -: 8];
    endfunction

    // Find the operator row whose first character is c
    function automatic t_op_hit op_lookup(input logic [7:0] c);
        t_op_hit res;
        res = '0;
        for (int i = 0; i < OP_COUNT; i++) begin
            if (!res.hit && OP_TAB[i].first == c) begin
                res.hit = 1'b1;
                res.idx = OP_W'(i);
            end
        end
        return res;
    endfunction

    // Single punctuation marks
    function automatic t_single single_lookup(input logic [7:0] c);
        t_single res;
        res.hit = 1'b1;
        case (c)
            "%":     res.kind = KIND_MOD;
            "~":     res.kind = KIND_TILDE;
            "^":     res.kind = KIND_XOR;
            "(":     res.kind = KIND_LPAREN;
            ")":     res.kind = KIND_RPAREN;
            "[":     res.kind = KIND_LBRACK;
            "]":     res.kind = KIND_RBRACK;
            "{":     res.kind = KIND_LBRACE;
            "}":     res.kind = KIND_RBRACE;
            ",":     res.kind = KIND_COMMA;
            ";":     res.kind = KIND_SEMI;
            ".":     res.kind = KIND_DOT;
            "\"":    res.kind = KIND_QUOTE;
            "#":     res.kind = KIND_HASH;
            default: begin
                res.hit  = 1'b0;
                res.kind = KIND_ERROR;
            end
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/csl_if.sv =====
// Stream interfaces of the lexer: source bytes in, tokens out.
// Depends on nothing; used by the front, back and top level.
`default_nettype none

interface csl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_input;

    modport source (output valid, output data_byte, output end_of_input, input ready);
    modport sink   (input valid, input data_byte, input end_of_input, output ready);
endinterface

interface csl_out_if;
    logic        valid;
    logic        ready;
    logic [5:0]  token_kind;
    logic [31:0] token_start;
    logic [7:0]  token_length;
    logic        too_long;
    logic        last_of_item;

    modport source (output valid, output token_kind, output token_start,
                    output token_length, output too_long, output last_of_item,
                    input ready);
    modport sink   (input valid, input token_kind, input token_start,
                    input token_length, input too_long, input last_of_item,
                    output ready);
endinterface

`default_nettype wire

// ===== hdl/csl_front.sv =====
// Front of the lexer: accepts one byte per beat, runs the scan state machine
// and classifies tokens into a pair record. Depends on csl_pkg and csl_if.
`default_nettype none

module csl_front #(
    parameter int MAX_TOKEN_LEN = 255,
    parameter int POSITION_BITS = 32
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    csl_in_if.sink              i_src,
    input  wire                 i_q_ready,
    output logic                o_push,
    output csl_pkg::t_tok_pair  o_pair
);

    localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);

    typedef enum logic [7:0] {
        MODE_IDLE  = 8'b0000_0001,
        MODE_WORD  = 8'b0000_0010,
        MODE_NUM   = 8'b0000_0100,
        MODE_SLASH = 8'b0000_1000,
        MODE_LINE  = 8'b0001_0000,
        MODE_BLOCK = 8'b0010_0000,
        MODE_BSTAR = 8'b0100_0000,
        MODE_OP    = 8'b1000_0000
    } t_mode;

    t_mode                          r_mode,  n_mode;
    logic [csl_pkg::OP_W-1:0]       r_op,    n_op;
    logic [POSITION_BITS-1:0]       r_start, n_start;
    logic [LEN_W-1:0]               r_len,   n_len;
    logic                           r_ovf,   n_ovf;
    logic [csl_pkg::KW_COUNT-1:0]   r_cand,  n_cand;
    logic [POSITION_BITS-1:0]       r_pos,   n_pos;

    logic [7:0]                     c;
    logic                           eoi, accept;
    logic                           is_alpha, is_digit, is_word, is_space;
    logic [csl_pkg::KW_COUNT-1:0]   m_add, m_first;
    csl_pkg::t_kind                 word_kind;
    logic [LEN_W-1:0]               g_len;
    logic                           g_ovf;
    logic [POSITION_BITS+31:0]      pos_ext, start_ext;
    logic [LEN_W+7:0]               len_ext;
    logic [31:0]                    pos32, start32;
    logic [7:0]                     len8;
    csl_pkg::t_op_row               row;
    csl_pkg::t_op_hit               op_hit;
    csl_pkg::t_single               sgl;
    csl_pkg::t_token                pend_tok, sb_tok, tok_a;
    t_mode                          sb_mode;
    logic [csl_pkg::OP_W-1:0]       sb_op;
    logic [LEN_W-1:0]               sb_len;
    logic [csl_pkg::KW_COUNT-1:0]   sb_cand;
    logic                           sb_emit;
    logic                           has_a, do_sb, has_b;

    assign c      = i_src.data_byte;
    assign eoi    = i_src.end_of_input;
    assign accept = i_src.valid && i_src.ready;
    assign i_src.ready = i_q_ready;

    // Character classes and table lookups
    assign is_alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    assign is_digit = (c >= "0" && c <= "9");
    assign is_word  = is_alpha || is_digit || (c == "_");
    assign is_space = (c == " ") || (c == "\n") || (c == "\t");
    assign op_hit   = csl_pkg::op_lookup(c);
    assign sgl      = csl_pkg::single_lookup(c);
    assign row      = csl_pkg::OP_TAB[r_op];

    // Width adaptation of position and length to the token fields
    assign pos_ext   = {32'd0, r_pos};
    assign start_ext = {32'd0, r_start};
    assign len_ext   = {8'd0, r_len};
    assign pos32     = pos_ext[31:0];
    assign start32   = start_ext[31:0];
    assign len8      = len_ext[7:0];

    // Keyword candidate masks for this byte, and the finished word's kind
    always_comb begin
        for (int k = 0; k < csl_pkg::KW_COUNT; k++) begin
            m_add[k] = !r_ovf && (r_len < LEN_W'(csl_pkg::KW_LEN[k])) &&
                       (csl_pkg::kw_char(k, r_len[csl_pkg::KW_IDX_W-1:0]) == c);
            m_first[k] = (csl_pkg::KW_TEXT[k][csl_pkg::KW_MAX_LEN*8-1 -: 8] == c);
        end
        word_kind = csl_pkg::KIND_IDENT;
        if (!r_ovf) begin
            for (int k = csl_pkg::KW_COUNT - 1; k >= 0; k--) begin
                if (r_cand[k] && r_len == LEN_W'(csl_pkg::KW_LEN[k])) begin
                    word_kind = csl_pkg::t_kind'(k);
                end
            end
        end
    end

    // Saturating length growth
    always_comb begin
        g_len = r_len;
        g_ovf = r_ovf;
        if (r_len < LEN_W'(MAX_TOKEN_LEN)) begin
            g_len = r_len + LEN_W'(1);
        end else begin
            g_ovf = 1'b1;
        end
    end

    // Token that the current scan state would flush
    always_comb begin
        pend_tok.start    = start32;
        pend_tok.length   = 8'd1;
        pend_tok.too_long = 1'b0;
        case (r_mode)
            MODE_WORD: begin
                pend_tok.kind     = word_kind;
                pend_tok.length   = len8;
                pend_tok.too_long = r_ovf;
            end
            MODE_NUM: begin
                pend_tok.kind     = csl_pkg::KIND_INT;
                pend_tok.length   = len8;
                pend_tok.too_long = r_ovf;
            end
            MODE_SLASH: pend_tok.kind = csl_pkg::KIND_DIV;
            MODE_OP:    pend_tok.kind = row.alone;
            default:    pend_tok.kind = csl_pkg::KIND_ERROR;
        endcase
    end

    // Classify the byte as the start of a new token
    always_comb begin
        sb_mode = MODE_IDLE;
        sb_op   = '0;
        sb_len  = '0;
        sb_cand = csl_pkg::KW_ALL;
        sb_emit = 1'b0;
        sb_tok  = '{kind: csl_pkg::KIND_ERROR, start: pos32, length: 8'd1, too_long: 1'b0};
        if (is_space) begin
            sb_mode = MODE_IDLE;
        end else if (is_alpha || c == "_") begin
            sb_mode = MODE_WORD;
            sb_len  = LEN_W'(1);
            sb_cand = m_first;
        end else if (is_digit) begin
            sb_mode = MODE_NUM;
            sb_len  = LEN_W'(1);
        end else if (c == "/") begin
            sb_mode = MODE_SLASH;
        end else if (op_hit.hit) begin
            sb_mode = MODE_OP;
            sb_op   = op_hit.idx;
        end else begin
            sb_emit     = 1'b1;
            sb_tok.kind = sgl.hit ? sgl.kind : csl_pkg::KIND_ERROR;
        end
    end

    // Next state of the scanner
    always_comb begin
        n_mode  = r_mode;
        n_op    = r_op;
        n_start = r_start;
        n_len   = r_len;
        n_ovf   = r_ovf;
        n_cand  = r_cand;
        n_pos   = r_pos + POSITION_BITS'(1);
        has_a   = 1'b0;
        do_sb   = 1'b0;
        tok_a   = pend_tok;
        if (eoi) begin
            // flush and return to the start of a new stream
            has_a   = r_mode inside {MODE_WORD, MODE_NUM, MODE_SLASH, MODE_OP};
            n_mode  = MODE_IDLE;
            n_op    = '0;
            n_start = '0;
            n_len   = '0;
            n_ovf   = 1'b0;
            n_cand  = csl_pkg::KW_ALL;
            n_pos   = '0;
        end else begin
            case (r_mode)
                MODE_WORD: begin
                    if (is_word) begin
                        n_cand = r_cand & m_add;
                        n_len  = g_len;
                        n_ovf  = g_ovf;
                    end else begin
                        has_a = 1'b1;
                        do_sb = 1'b1;
                    end
                end
                MODE_NUM: begin
                    if (is_digit) begin
                        n_len = g_len;
                        n_ovf = g_ovf;
                    end else begin
                        has_a = 1'b1;
                        do_sb = 1'b1;
                    end
                end
                MODE_SLASH: begin
                    if (c == "/") begin
                        n_mode = MODE_LINE;
                    end else if (c == "*") begin
                        n_mode = MODE_BLOCK;
                    end else begin
                        has_a = 1'b1;
                        do_sb = 1'b1;
                    end
                end
                MODE_LINE: begin
                    if (c == "\n") n_mode = MODE_IDLE;
                end
                MODE_BLOCK: begin
                    if (c == "*") n_mode = MODE_BSTAR;
                end
                MODE_BSTAR: begin
                    if (c == "/") begin
                        n_mode = MODE_IDLE;
                    end else if (c != "*") begin
                        n_mode = MODE_BLOCK;
                    end
                end
                MODE_OP: begin
                    if (row.sec_a != csl_pkg::CH_NONE && c == row.sec_a) begin
                        has_a  = 1'b1;
                        tok_a  = '{kind: row.kind_a, start: start32, length: 8'd2,
                                   too_long: 1'b0};
                        n_mode = MODE_IDLE;
                    end else if (row.sec_b != csl_pkg::CH_NONE && c == row.sec_b) begin
                        has_a  = 1'b1;
                        tok_a  = '{kind: row.kind_b, start: start32, length: 8'd2,
                                   too_long: 1'b0};
                        n_mode = MODE_IDLE;
                    end else begin
                        has_a = 1'b1;
                        do_sb = 1'b1;
                    end
                end
                default: do_sb = 1'b1;
            endcase
            if (do_sb) begin
                n_mode  = sb_mode;
                n_op    = sb_op;
                n_start = r_pos;
                n_len   = sb_len;
                n_ovf   = 1'b0;
                n_cand  = sb_cand;
            end
        end
    end

    // Pack up to two tokens for the queue
    assign has_b       = do_sb && sb_emit;
    assign o_push      = accept && (has_a || has_b);
    assign o_pair.two  = has_a && has_b;
    assign o_pair.tok0 = has_a ? tok_a : sb_tok;
    assign o_pair.tok1 = sb_tok;

    // Advance the scanner on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_op    <= '0;
            r_start <= '0;
            r_len   <= '0;
            r_ovf   <= 1'b0;
            r_cand  <= csl_pkg::KW_ALL;
            r_pos   <= '0;
        end else if (accept) begin
            r_mode  <= n_mode;
            r_op    <= n_op;
            r_start <= n_start;
            r_len   <= n_len;
            r_ovf   <= n_ovf;
            r_cand  <= n_cand;
            r_pos   <= n_pos;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/csl_queue.sv =====
// Short queue of token pairs between the front and the back.
// Depends on csl_pkg.
`default_nettype none

module csl_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  csl_pkg::t_tok_pair  i_pair,
    output logic                o_ready,
    output logic                o_head_valid,
    output csl_pkg::t_tok_pair  o_head,
    input  wire                 i_pop
);

    csl_pkg::t_tok_pair               r_mem [csl_pkg::QUEUE_DEPTH];
    logic [csl_pkg::QPTR_W-1:0]       r_wr, r_rd;
    logic [csl_pkg::QPTR_W:0]         r_cnt, n_cnt;

    assign o_ready      = (r_cnt != (csl_pkg::QPTR_W + 1)'(csl_pkg::QUEUE_DEPTH));
    assign o_head_valid = (r_cnt != '0);
    assign o_head       = r_mem[r_rd];

    // Track occupancy
    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + (csl_pkg::QPTR_W + 1)'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - (csl_pkg::QPTR_W + 1)'(1);
        end
    end

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + csl_pkg::QPTR_W'(1);
            if (i_pop)  r_rd <= r_rd + csl_pkg::QPTR_W'(1);
            r_cnt <= n_cnt;
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_pair;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/csl_back.sv =====
// Back of the lexer: splits queued token pairs into single output beats and
// holds them in an output register. Depends on csl_pkg and csl_if.
`default_nettype none

module csl_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_head_valid,
    input  csl_pkg::t_tok_pair  i_head,
    output logic                o_pop,
    csl_out_if.source           o_tok
);

    logic               r_vld;
    logic               r_sel;
    logic               r_last;
    csl_pkg::t_token    r_tok;
    logic               load, take, last;
    csl_pkg::t_token    tok;

    // Pick the next token of the head pair
    assign load  = !r_vld || o_tok.ready;
    assign take  = load && i_head_valid;
    assign tok   = r_sel ? i_head.tok1 : i_head.tok0;
    assign last  = r_sel || !i_head.two;
    assign o_pop = take && last;

    // Hold the output beat until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_sel <= 1'b0;
        end else begin
            if (load) r_vld <= i_head_valid;
            if (take) r_sel <= !last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_tok  <= tok;
            r_last <= last;
        end
    end

    assign o_tok.valid        = r_vld;
    assign o_tok.token_kind   = r_tok.kind;
    assign o_tok.token_start  = r_tok.start;
    assign o_tok.token_length = r_tok.length;
    assign o_tok.too_long     = r_tok.too_long;
    assign o_tok.last_of_item = r_last;

endmodule

`default_nettype wire

// ===== hdl/c_subset_lexer_unit.sv =====
// A token passes from the edge that accepts the byte that ends it into the pair queue,
// and from the queue head into the output register, where it waits until taken.
// Throughput: one byte per cycle; tokens leave at one per cycle from the output
// register while the output is ready, and a 4-entry pair queue lets a byte that
// ends two tokens pass. Input ready drops only while that queue is full.
// Reset (synchronous, active low) returns the scanner to idle at offset 0 and
// empties the queue and the output register.
`default_nettype none

module c_subset_lexer_unit #(
    parameter int MAX_TOKEN_LEN = 255,
    parameter int POSITION_BITS = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    csl_in_if.sink      i_src,
    csl_out_if.source   o_tok
);

    logic                   q_ready, push, pop, head_valid;
    csl_pkg::t_tok_pair     pair, head;

    // Scan and classify
    csl_front #(
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN),
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_src     (i_src),
        .i_q_ready (q_ready),
        .o_push    (push),
        .o_pair    (pair)
    );

    // Decouple
    csl_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_pair       (pair),
        .o_ready      (q_ready),
        .o_head_valid (head_valid),
        .o_head       (head),
        .i_pop        (pop)
    );

    // Serialize tokens
    csl_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_tok        (o_tok)
    );

endmodule

`default_nettype wire

// ===== hdl/csl_checker.sv =====
// Port-level checks on the token stream of the lexer, bound to the top level.
// Depends on csl_pkg and on c_subset_lexer_unit.
`default_nettype none

module csl_checker (
    input wire          i_clk,
    input wire          i_rst_n,
    input wire          i_valid,
    input wire          i_ready,
    input wire [5:0]    i_kind,
    input wire [31:0]   i_start,
    input wire [7:0]    i_length,
    input wire          i_too_long,
    input wire          i_last
);

    // A stalled beat holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid &&
            $stable({i_kind, i_start, i_length, i_too_long, i_last}))
        else $error("token beat changed while stalled");

    // Only words and numbers can saturate, and a saturated word is an identifier
    a_too_long_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_too_long |-> i_kind == csl_pkg::KIND_IDENT ||
            i_kind == csl_pkg::KIND_INT)
        else $error("too_long on a token that cannot saturate");

    // Operators, punctuation and errors are one or two characters
    a_op_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_kind > csl_pkg::KIND_INT |-> i_length == 8'd1 || i_length == 8'd2)
        else $error("operator token with bad length");

    // Kind stays within the code space
    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_kind <= csl_pkg::KIND_ERROR)
        else $error("token kind out of range");

endmodule

bind c_subset_lexer_unit csl_checker u_csl_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (o_tok.valid),
    .i_ready    (o_tok.ready),
    .i_kind     (o_tok.token_kind),
    .i_start    (o_tok.token_start),
    .i_length   (o_tok.token_length),
    .i_too_long (o_tok.too_long),
    .i_last     (o_tok.last_of_item)
);

`default_nettype wire
